// File: rtl/dq_pkg.sv
// ============================================================================
// dq_pkg
// Shared types and constants of the double-ended queue: operation codes,
// the word format and the flags that travel with a result.
// ============================================================================
package dq_pkg;

    localparam int WORD_W = 32;
    localparam int MODE_W = 3;

    // Value reported where no word exists (pop on empty, front or back of empty).
    localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_QUERY      = 3'd4
    } dq_mode_t;

    typedef struct packed {
        logic pop_valid;
        logic push_dropped;
        logic is_empty;
    } dq_flags_t;

endpackage

// File: rtl/dq_ram.sv
// ============================================================================
// dq_ram
// Ring storage of the queue: one write port and two read ports, with the read
// data registered when the read is enabled.
// ============================================================================
module dq_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [$clog2(DEPTH)-1:0]              wr_addr,
    input  logic signed [dq_pkg::WORD_W-1:0]      wr_data,
    input  logic                                  rd_en,
    input  logic [$clog2(DEPTH)-1:0]              rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]              rd_addr_b,
    output logic signed [dq_pkg::WORD_W-1:0]      rd_data_a,
    output logic signed [dq_pkg::WORD_W-1:0]      rd_data_b
);

    logic signed [dq_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// File: rtl/dq_ctrl.sv
// ============================================================================
// dq_ctrl
// Pointer and count bookkeeping of the queue. Applies one operation, writes
// the pushed word, then reads the new front and back words from the ring.
// ============================================================================
module dq_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // operation beat
    input  logic                                  op_valid,
    output logic                                  op_ready,
    input  logic [dq_pkg::MODE_W-1:0]             op_mode,
    input  logic signed [dq_pkg::WORD_W-1:0]      op_value,
    // ring port
    output logic                                  wr_en,
    output logic [$clog2(DEPTH)-1:0]              wr_addr,
    output logic signed [dq_pkg::WORD_W-1:0]      wr_data,
    output logic                                  rd_en,
    output logic [$clog2(DEPTH)-1:0]              rd_addr_a,
    output logic [$clog2(DEPTH)-1:0]              rd_addr_b,
    input  logic signed [dq_pkg::WORD_W-1:0]      rd_data_a,
    input  logic signed [dq_pkg::WORD_W-1:0]      rd_data_b,
    // result beat
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [dq_pkg::WORD_W-1:0]      res_popped,
    output logic [$clog2(DEPTH+1)-1:0]            res_count,
    output logic signed [dq_pkg::WORD_W-1:0]      res_front,
    output logic signed [dq_pkg::WORD_W-1:0]      res_back,
    output dq_pkg::dq_flags_t                     res_flags
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CAPT
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic signed [dq_pkg::WORD_W-1:0] front_reg, front_next;
    logic signed [dq_pkg::WORD_W-1:0] back_reg, back_next;
    logic signed [dq_pkg::WORD_W-1:0] popped_reg, popped_next;
    logic                           pop_valid_reg, pop_valid_next;
    logic                           dropped_reg, dropped_next;

    logic [CW:0]                    end_sum;
    logic [AW-1:0]                  end_slot;
    logic [AW-1:0]                  tail_slot;
    logic [AW-1:0]                  head_dec;
    logic [AW-1:0]                  head_inc;
    logic                           is_full;
    logic                           is_zero;
    logic                           op_accept;

    // The slot just past the back word; head + count stays below twice DEPTH.
    assign end_sum   = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign end_slot  = (end_sum >= (CW+1)'(DEPTH)) ? AW'(end_sum - (CW+1)'(DEPTH))
                                                   : AW'(end_sum);
    assign tail_slot = (end_slot == '0) ? AW'(DEPTH - 1) : end_slot - 1'b1;
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_zero   = (count_reg == '0);

    assign op_ready  = (state_reg == ST_IDLE);
    assign op_accept = op_valid && op_ready;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        popped_next    = popped_reg;
        pop_valid_next = pop_valid_reg;
        dropped_next   = dropped_reg;
        wr_en          = 1'b0;
        wr_addr        = end_slot;
        wr_data        = op_value;
        rd_en          = 1'b0;
        rd_addr_a      = head_reg;
        rd_addr_b      = tail_slot;

        case (state_reg)
            ST_IDLE: begin
                if (op_valid) begin
                    popped_next    = dq_pkg::NONE_WORD;
                    pop_valid_next = 1'b0;
                    dropped_next   = 1'b0;
                    state_next     = ST_READ;
                    case (op_mode)
                        dq_pkg::MODE_PUSH_FRONT: begin
                            if (is_full) begin
                                dropped_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dq_pkg::MODE_PUSH_BACK: begin
                            if (is_full) begin
                                dropped_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dq_pkg::MODE_POP_FRONT: begin
                            if (!is_zero) begin
                                popped_next    = front_reg;
                                pop_valid_next = 1'b1;
                                head_next      = head_inc;
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        dq_pkg::MODE_POP_BACK: begin
                            if (!is_zero) begin
                                popped_next    = back_reg;
                                pop_valid_next = 1'b1;
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_CAPT;
            end
            ST_CAPT: begin
                if (res_ready) begin
                    front_next = res_front;
                    back_next  = res_back;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid              = (state_reg == ST_CAPT);
    assign res_popped             = popped_reg;
    assign res_count              = count_reg;
    assign res_front              = is_zero ? dq_pkg::NONE_WORD : rd_data_a;
    assign res_back               = is_zero ? dq_pkg::NONE_WORD : rd_data_b;
    assign res_flags.pop_valid    = pop_valid_reg;
    assign res_flags.push_dropped = dropped_reg;
    assign res_flags.is_empty     = is_zero;

    always_ff @(posedge aclk) begin
        front_reg     <= front_next;
        back_reg      <= back_next;
        popped_reg    <= popped_next;
        pop_valid_reg <= pop_valid_next;
        dropped_reg   <= dropped_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // The ring never holds more than DEPTH words and the head stays in range.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= AW'(DEPTH - 1))
        else $error("head index out of range");

    // Pointer state moves only when an operation is taken.
    a_count_moves_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !op_accept |=> count_reg == $past(count_reg) && head_reg == $past(head_reg))
        else $error("queue state changed without an operation");

    // A single operation cannot both pop a word and refuse a push.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res_flags.pop_valid && res_flags.push_dropped))
        else $error("pop and dropped push reported together");

    // Every taken operation passes through the ring read before its result.
    a_read_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        op_accept |=> rd_en ##1 res_valid)
        else $error("operation skipped the ring read");

endmodule

// File: rtl/double_ended_queue.sv
// ============================================================================
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words with push and pop at
// either end, one result beat per operation.
// ============================================================================
// Each operation goes through the controller's states in order: on acceptance
// the pointers are updated and a pushed word is written into the ring, then the
// ring's two read ports fetch the new front and back words, then the result is
// offered and held in the controller until the output register takes it. Only
// then is the next operation accepted, so the controller takes no new operation
// before the result of the last one has been handed on. The output register
// holds a finished result while the next operation is taken; if that result is
// still not drained, the second result waits in the controller. The ring needs
// no clearing after reset.
module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] push_value
    input  logic [31:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // popped_value, pop_valid, push_dropped, entry_count, is_empty,
    // front_value, back_value (lowest bit first), zero padded to bytes
    output logic [((99 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((99 + CW + 7) / 8) * 8;

    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic signed [dq_pkg::WORD_W-1:0] wr_data;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr_a;
    logic [AW-1:0]                    rd_addr_b;
    logic signed [dq_pkg::WORD_W-1:0] rd_data_a;
    logic signed [dq_pkg::WORD_W-1:0] rd_data_b;

    logic                             res_valid;
    logic                             res_ready;
    logic signed [dq_pkg::WORD_W-1:0] res_popped;
    logic [CW-1:0]                    res_count;
    logic signed [dq_pkg::WORD_W-1:0] res_front;
    logic signed [dq_pkg::WORD_W-1:0] res_back;
    dq_pkg::dq_flags_t                res_flags;

    logic                             m_valid_reg;
    logic signed [dq_pkg::WORD_W-1:0] m_popped_reg;
    logic [CW-1:0]                    m_count_reg;
    logic signed [dq_pkg::WORD_W-1:0] m_front_reg;
    logic signed [dq_pkg::WORD_W-1:0] m_back_reg;
    dq_pkg::dq_flags_t                m_flags_reg;

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (s_tvalid),
        .op_ready   (s_tready),
        .op_mode    (s_tuser),
        .op_value   (s_tdata),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_popped (res_popped),
        .res_count  (res_count),
        .res_front  (res_front),
        .res_back   (res_back),
        .res_flags  (res_flags)
    );

    dq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Output register: takes a new result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_popped_reg <= res_popped;
            m_count_reg  <= res_count;
            m_front_reg  <= res_front;
            m_back_reg   <= res_back;
            m_flags_reg  <= res_flags;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_back_reg, m_front_reg, m_flags_reg.is_empty, m_count_reg,
                              m_flags_reg.push_dropped, m_flags_reg.pop_valid,
                              m_popped_reg});

endmodule

// File: tb/deque_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// deque_checker
// Watches both stream channels of the double-ended queue. Every accepted
// input beat is run through a ring-store predictor of its own, and every
// accepted result beat is compared field by field with the oldest
// prediction. Mismatches are counted and handed to the testbench top.
// ============================================================================
module deque_checker #(
    parameter int DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [31:0] push_value
    input  logic [31:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // popped_value, pop_valid, push_dropped, entry_count, is_empty,
    // front_value, back_value (lowest bit first), zero padded to bytes
    input  logic [((99 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
    output int          fail_count,
    output int          pending_results
);

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CNT_LO  = 34;
    localparam int EMPTY_B = CNT_LO + COUNT_W;
    localparam int FRONT_LO = EMPTY_B + 1;
    localparam int BACK_LO  = FRONT_LO + 32;

    typedef struct {
        logic [31:0]        popped_value;
        logic               pop_valid;
        logic               push_dropped;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic [31:0]        front_value;
        logic [31:0]        back_value;
    } deque_result_t;

    logic [31:0]   ring [DEPTH];
    int unsigned   head;
    int unsigned   count;
    deque_result_t predicted_q [$];

    // Applies one operation to the predicted deque and returns the result beat.
    task automatic apply_op(input logic [2:0] mode, input logic [31:0] word,
                            output deque_result_t r);
        int unsigned tail;
        r.popped_value = dq_pkg::NONE_WORD;
        r.pop_valid    = 1'b0;
        r.push_dropped = 1'b0;
        case (mode)
            dq_pkg::MODE_PUSH_FRONT: begin
                if (count >= DEPTH) begin
                    r.push_dropped = 1'b1;
                end else begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = word;
                    count++;
                end
            end
            dq_pkg::MODE_PUSH_BACK: begin
                if (count >= DEPTH) begin
                    r.push_dropped = 1'b1;
                end else begin
                    ring[(head + count) % DEPTH] = word;
                    count++;
                end
            end
            dq_pkg::MODE_POP_FRONT: begin
                if (count != 0) begin
                    r.popped_value = ring[head];
                    r.pop_valid = 1'b1;
                    head = (head + 1) % DEPTH;
                    count--;
                end
            end
            dq_pkg::MODE_POP_BACK: begin
                if (count != 0) begin
                    r.popped_value = ring[(head + count + DEPTH - 1) % DEPTH];
                    r.pop_valid = 1'b1;
                    count--;
                end
            end
            default: begin
                // Query and the unused codes leave the deque alone.
            end
        endcase
        tail = (head + count + DEPTH - 1) % DEPTH;
        r.entry_count = COUNT_W'(count);
        r.is_empty    = (count == 0);
        r.front_value = (count == 0) ? dq_pkg::NONE_WORD : ring[head];
        r.back_value  = (count == 0) ? dq_pkg::NONE_WORD : ring[tail];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout int errs);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin : watch
        deque_result_t r;
        deque_result_t e;
        int errs;
        if (!aresetn) begin
            head = 0;
            count = 0;
            predicted_q.delete();
            fail_count <= 0;
            pending_results <= 0;
        end else begin
            errs = 0;
            // Predict first: a result leaving now always belongs to an older beat.
            if (s_tvalid && s_tready) begin
                apply_op(s_tuser, s_tdata, r);
                predicted_q.insert(predicted_q.size(), r);
            end
            if (m_tvalid && m_tready) begin
                if (predicted_q.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    errs++;
                end else begin
                    e = predicted_q[0];
                    predicted_q.delete(0);
                    check_field("popped_value", e.popped_value, m_tdata[31:0], errs);
                    check_field("pop_valid", 32'(e.pop_valid), 32'(m_tdata[32]), errs);
                    check_field("push_dropped", 32'(e.push_dropped), 32'(m_tdata[33]),
                                errs);
                    check_field("entry_count", 32'(e.entry_count),
                                32'(m_tdata[CNT_LO +: COUNT_W]), errs);
                    check_field("is_empty", 32'(e.is_empty), 32'(m_tdata[EMPTY_B]), errs);
                    check_field("front_value", e.front_value, m_tdata[FRONT_LO +: 32],
                                errs);
                    check_field("back_value", e.back_value, m_tdata[BACK_LO +: 32], errs);
                end
            end
            fail_count <= fail_count + errs;
            pending_results <= predicted_q.size();
        end
    end

endmodule

// File: tb/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ============================================================================
// double_ended_queue_test
// Stimulus and verdict for the double-ended queue. A short directed run
// covers empty pops, the unused mode codes and extreme words; random phases
// then fill the deque to full, work around the full mark, drain it back to
// half and finish with a balanced mix, with random gaps on both channels.
// ============================================================================
module double_ended_queue_test;

    localparam int DEPTH     = 1024;
    localparam int DATA_W    = ((99 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam int MAX_CYCLES = 400000;

    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;
    logic [2:0]        s_tuser  = dq_pkg::MODE_QUERY;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    int          fail_count;
    int          pending_results;
    int unsigned words_held = 0;
    logic        calm = 1'b0;
    int          cycles = 0;

    always #5 aclk = ~aclk;

    double_ended_queue #(.DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    deque_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one beat, with a random idle gap in front of it unless calm.
    task automatic send_op(input logic [2:0] mode, input logic [31:0] word);
        if (!calm) begin
            while ($urandom_range(0, 99) < 19) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        // Track the fill level only to steer the random phases.
        if (mode == dq_pkg::MODE_PUSH_FRONT || mode == dq_pkg::MODE_PUSH_BACK) begin
            if (words_held < DEPTH) words_held++;
        end else if (mode == dq_pkg::MODE_POP_FRONT || mode == dq_pkg::MODE_POP_BACK) begin
            if (words_held > 0) words_held--;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    function automatic logic [2:0] pick_mode(input int push_pct);
        int r;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_BACK : dq_pkg::MODE_PUSH_FRONT;
        r = $urandom_range(0, 9);
        if (r < 4) return dq_pkg::MODE_POP_FRONT;
        if (r < 8) return dq_pkg::MODE_POP_BACK;
        if (r == 8) return dq_pkg::MODE_QUERY;
        return 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty deque: query, pops at both ends and the unused codes.
        send_op(dq_pkg::MODE_QUERY, 32'h0);
        send_op(dq_pkg::MODE_POP_FRONT, 32'h1234_5678);
        send_op(dq_pkg::MODE_POP_BACK, 32'hffff_ffff);
        send_op(MODE_SPARE_5, 32'h0);
        send_op(MODE_SPARE_6, 32'h8000_0000);
        send_op(MODE_SPARE_7, 32'h7fff_ffff);
        send_op(dq_pkg::MODE_PUSH_FRONT, 32'h7fff_ffff);
        send_op(dq_pkg::MODE_PUSH_BACK, 32'h8000_0000);
        send_op(dq_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
        send_op(dq_pkg::MODE_PUSH_BACK, 32'hffff_ffff);
        send_op(dq_pkg::MODE_QUERY, 32'hdead_beef);
        send_op(dq_pkg::MODE_POP_BACK, 32'h0);
        send_op(dq_pkg::MODE_POP_FRONT, 32'h0);
        send_op(MODE_SPARE_7, 32'h0);
        send_op(dq_pkg::MODE_POP_FRONT, 32'h0);
        send_op(dq_pkg::MODE_POP_BACK, 32'h0);
        send_op(dq_pkg::MODE_POP_FRONT, 32'h0);
        send_op(dq_pkg::MODE_PUSH_BACK, 32'haaaa_aaaa);
        send_op(dq_pkg::MODE_POP_BACK, 32'h0);
        send_op(dq_pkg::MODE_PUSH_FRONT, 32'h5555_5555);
        send_op(dq_pkg::MODE_PUSH_BACK, 32'haaaa_aaaa);
        send_op(dq_pkg::MODE_POP_FRONT, 32'h0);
        send_op(dq_pkg::MODE_POP_FRONT, 32'h0);
        wait_drained();

        // Fill to full; the first stretch runs without any idling.
        n = 0;
        while (words_held < DEPTH) begin
            calm <= (n < 300);
            send_op(pick_mode(95), pick_word());
            n++;
        end
        calm <= 1'b0;
        // Work around the full mark so that pushes get dropped.
        repeat (60) send_op(pick_mode(60), pick_word());
        wait_drained();

        // Drain back to half full, then a pop-heavy stretch and a balanced mix.
        while (words_held > DEPTH / 2) send_op(pick_mode(5), pick_word());
        repeat (30) send_op(pick_mode(15), pick_word());
        repeat (40) send_op(pick_mode(50), pick_word());
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: double_ended_queue.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
tb/deque_checker.sv
tb/double_ended_queue_test.sv
